// ----- hdl/bbp_pkg.sv -----
// Shared types, codes and widths of the balanced block partition block.
`timescale 1ns / 1ps

package bbp_pkg;

   localparam int DATA_W  = 16;
   localparam int CNT_W   = $clog2(DATA_W);
   localparam int ADDR_W  = 4;
   localparam int PDATA_W = 32;

   typedef enum logic [1:0] {
      OP_SIZE  = 2'd0,
      OP_FIRST = 2'd1,
      OP_OWNER = 2'd2
   } bbp_op_type;

   typedef enum logic [1:0] {
      REG_SIDE   = 2'd0,
      REG_COUNT  = 2'd1,
      REG_LAYOUT = 2'd2
   } bbp_reg_type;

   typedef enum logic [2:0] {
      CFG_IDLE,
      CFG_LOAD,
      CFG_DIV,
      CFG_BIG,
      CFG_LEAD
   } bbp_cfg_state_type;

   // Configuration and the quantities derived from it.
   typedef struct packed {
      logic [DATA_W-1:0] side;
      logic [DATA_W-1:0] count;
      logic [DATA_W-1:0] q;
      logic [DATA_W-1:0] r;
      logic [DATA_W-1:0] big;
      logic [DATA_W-1:0] lead;
      logic              by_col;
   } bbp_cfg_type;

   // Item after decode, before the multiplier.
   typedef struct packed {
      logic              oor;
      logic              div_en;
      logic [DATA_W-1:0] div_add;
      logic [DATA_W-1:0] addend;
      logic [DATA_W-1:0] mul_a;
      logic [DATA_W-1:0] mul_b;
      logic [DATA_W-1:0] dq;
      logic [DATA_W-1:0] divisor;
   } bbp_pre_type;

   // Item inside the divider pipeline.
   typedef struct packed {
      logic              oor;
      logic              div_en;
      logic [DATA_W-1:0] div_add;
      logic [DATA_W-1:0] addend;
      logic [DATA_W-1:0] prod;
      logic [DATA_W-1:0] rem;
      logic [DATA_W-1:0] dq;
      logic [DATA_W-1:0] divisor;
   } bbp_lane_type;

endpackage

// ----- hdl/bbp_req_if.sv -----
// Request channel interface: valid/ready handshake and request payload.
`timescale 1ns / 1ps

interface bbp_req_if import bbp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        op;
   logic [DATA_W-1:0] value;
   logic              want_column;

   modport source (output valid, output op, output value, output want_column, input ready);
   modport sink   (input valid, input op, input value, input want_column, output ready);
endinterface

// ----- hdl/bbp_rsp_if.sv -----
// Response channel interface: valid/ready handshake and response payload.
`timescale 1ns / 1ps

interface bbp_rsp_if import bbp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] result;
   logic              out_of_range;

   modport source (output valid, output result, output out_of_range, input ready);
   modport sink   (input valid, input result, input out_of_range, output ready);
endinterface

// ----- hdl/bbp_csr.sv -----
// Configuration registers and the sequencer that derives quotient and remainder.
`timescale 1ns / 1ps

module bbp_csr import bbp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [ADDR_W-1:0]  csr_paddr,
   input  logic [PDATA_W-1:0] csr_pwdata,
   output logic [PDATA_W-1:0] csr_prdata,
   output logic               csr_pready,
   output bbp_cfg_type        cfg,
   output logic               busy
);

   logic [DATA_W-1:0] side_ff, side_in;
   logic [DATA_W-1:0] count_ff, count_in;
   logic              layout_ff, layout_in;

   bbp_cfg_state_type state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] dq_ff, dq_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] q_ff, q_in;
   logic [DATA_W-1:0] r_ff, r_in;
   logic [DATA_W-1:0] big_ff, big_in;
   logic [DATA_W-1:0] lead_ff, lead_in;

   logic                wr;
   bbp_reg_type         idx;
   logic [DATA_W-1:0]   n_eff;
   logic [DATA_W:0]     rem_sh;
   logic [DATA_W:0]     diff;
   logic                ge;
   logic [2*DATA_W-1:0] lead_prod;

   assign csr_pready = 1'b1;
   assign wr         = csr_psel & csr_penable & csr_pwrite;
   assign idx        = bbp_reg_type'(csr_paddr[3:2]);
   // A block count of zero behaves as one.
   assign n_eff      = (count_ff == '0) ? DATA_W'(1) : count_ff;

   always_comb begin
      side_in   = side_ff;
      count_in  = count_ff;
      layout_in = layout_ff;
      if (wr) begin
         case (idx)
            REG_SIDE:   side_in   = csr_pwdata[DATA_W-1:0];
            REG_COUNT:  count_in  = csr_pwdata[DATA_W-1:0];
            REG_LAYOUT: layout_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_SIDE:   csr_prdata = PDATA_W'(side_ff);
         REG_COUNT:  csr_prdata = PDATA_W'(count_ff);
         REG_LAYOUT: csr_prdata = PDATA_W'(layout_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // Next state. Any write restarts the derivation from the updated registers.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CFG_IDLE: state_in = CFG_IDLE;
         CFG_LOAD: state_in = CFG_DIV;
         CFG_DIV:  state_in = (cnt_ff == CNT_W'(DATA_W-1)) ? CFG_BIG : CFG_DIV;
         CFG_BIG:  state_in = CFG_LEAD;
         CFG_LEAD: state_in = CFG_IDLE;
         default:  state_in = CFG_IDLE;
      endcase
      if (wr) begin
         state_in = CFG_LOAD;
      end
   end

   assign rem_sh    = {rem_ff, dq_ff[DATA_W-1]};
   assign diff      = rem_sh - {1'b0, n_eff};
   assign ge        = rem_sh >= {1'b0, n_eff};
   assign lead_prod = big_ff * r_ff;

   // Outputs and datapath updates of the sequencer.
   always_comb begin
      busy    = (state_ff != CFG_IDLE);
      cnt_in  = cnt_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      big_in  = big_ff;
      lead_in = lead_ff;
      case (state_ff)
         CFG_LOAD: begin
            cnt_in = '0;
            dq_in  = side_ff;
            rem_in = '0;
         end
         CFG_DIV: begin
            cnt_in = cnt_ff + CNT_W'(1);
            rem_in = ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
            dq_in  = {dq_ff[DATA_W-2:0], ge};
         end
         CFG_BIG: begin
            q_in   = dq_ff;
            r_in   = rem_ff;
            big_in = dq_ff + DATA_W'(rem_ff != '0);
         end
         CFG_LEAD: begin
            lead_in = lead_prod[DATA_W-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff   <= DATA_W'(1);
         count_ff  <= DATA_W'(1);
         layout_ff <= 1'b1;
         state_ff  <= CFG_LOAD;
      end else begin
         side_ff   <= side_in;
         count_ff  <= count_in;
         layout_ff <= layout_in;
         state_ff  <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      dq_ff   <= dq_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      r_ff    <= r_in;
      big_ff  <= big_in;
      lead_ff <= lead_in;
   end

   assign cfg.side   = side_ff;
   assign cfg.count  = n_eff;
   assign cfg.q      = q_ff;
   assign cfg.r      = r_ff;
   assign cfg.big    = big_ff;
   assign cfg.lead   = lead_ff;
   assign cfg.by_col = layout_ff;

endmodule

// ----- hdl/bbp_prep.sv -----
// Decode stage: range checks and operand selection for multiplier and divider.
`timescale 1ns / 1ps

module bbp_prep import bbp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [1:0]        op,
   input  logic [DATA_W-1:0] value,
   input  logic              want_column,
   input  bbp_cfg_type       cfg,
   output logic              out_valid,
   input  logic              out_ready,
   output bbp_pre_type       out_item
);

   logic        valid_ff, valid_in;
   bbp_pre_type item_ff, item_in;

   assign in_ready = ~valid_ff | out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      item_in         = '0;
      item_in.divisor = DATA_W'(1);
      case (bbp_op_type'(op))
         OP_SIZE: begin
            if (value >= cfg.count) begin
               item_in.oor = 1'b1;
            end else begin
               item_in.addend = cfg.q + DATA_W'(cfg.r > value);
            end
         end
         OP_FIRST: begin
            if (value >= cfg.count) begin
               item_in.oor = 1'b1;
            end else if (cfg.by_col != want_column) begin
               item_in.addend = '0;
            end else if (value > cfg.r) begin
               item_in.mul_a  = value - cfg.r;
               item_in.mul_b  = cfg.q;
               item_in.addend = cfg.lead;
            end else begin
               item_in.mul_a = value;
               item_in.mul_b = cfg.big;
            end
         end
         OP_OWNER: begin
            if (value >= cfg.side) begin
               item_in.oor = 1'b1;
            end else begin
               item_in.div_en = 1'b1;
               if (value < cfg.lead) begin
                  item_in.dq      = value;
                  item_in.divisor = cfg.big;
               end else begin
                  item_in.dq      = value - cfg.lead;
                  item_in.divisor = cfg.q;
                  item_in.div_add = cfg.r;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ----- hdl/bbp_mul_stage.sv -----
// Multiplier stage: forms the product for first-index requests.
`timescale 1ns / 1ps

module bbp_mul_stage import bbp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  bbp_pre_type  in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output bbp_lane_type out_lane
);

   logic                valid_ff, valid_in;
   bbp_lane_type        lane_ff, lane_in;
   logic [2*DATA_W-1:0] prod;

   assign in_ready = ~valid_ff | out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;
   assign prod     = in_item.mul_a * in_item.mul_b;

   always_comb begin
      lane_in.oor     = in_item.oor;
      lane_in.div_en  = in_item.div_en;
      lane_in.div_add = in_item.div_add;
      lane_in.addend  = in_item.addend;
      lane_in.prod    = prod[DATA_W-1:0];
      lane_in.rem     = '0;
      lane_in.dq      = in_item.dq;
      lane_in.divisor = in_item.divisor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         lane_ff <= lane_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;

endmodule

// ----- hdl/bbp_div_stage.sv -----
// One restoring-division stage: retires one quotient bit per item.
`timescale 1ns / 1ps

module bbp_div_stage import bbp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  bbp_lane_type in_lane,
   output logic         out_valid,
   input  logic         out_ready,
   output bbp_lane_type out_lane
);

   logic            valid_ff, valid_in;
   bbp_lane_type    lane_ff, lane_in;
   logic [DATA_W:0] rem_sh;
   logic [DATA_W:0] diff;
   logic            ge;

   assign in_ready = ~valid_ff | out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   assign rem_sh = {in_lane.rem, in_lane.dq[DATA_W-1]};
   assign diff   = rem_sh - {1'b0, in_lane.divisor};
   assign ge     = rem_sh >= {1'b0, in_lane.divisor};

   always_comb begin
      lane_in     = in_lane;
      lane_in.rem = ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
      lane_in.dq  = {in_lane.dq[DATA_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         lane_ff <= lane_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;

endmodule

// ----- hdl/balanced_block_partition.sv -----
// Top level of the balanced block partition block.
`timescale 1ns / 1ps

// The block splits a range of "side" elements into a configured number of
// blocks whose sizes differ by at most one, larger blocks first, and answers
// three kinds of request: the size of a block, the first index of a block,
// and the block that holds an element index. A request transfer may be taken
// on every clock cycle, and each request yields exactly one response, in
// order. The path is a pipeline of a decode stage, a multiplier stage,
// sixteen restoring division stages (one quotient bit each) and an output
// register; every stage holds its item while the stage after it is full, so
// a stalled response side backs up the pipeline without losing or repeating
// anything, and requests keep being taken while there are empty stages. The
// quotient and remainder of side by the block count are derived by a
// one-bit-per-cycle sequencer after reset and after every register write;
// during the derivation no request is taken (register writes are always
// taken). Registers: side at byte address 0, the block count at 4 (zero acts
// as one), by_column_layout at 8.

module balanced_block_partition import bbp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   bbp_req_if.sink            req_port,
   bbp_rsp_if.source          rsp_port,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [ADDR_W-1:0]  csr_paddr,
   input  logic [PDATA_W-1:0] csr_pwdata,
   output logic [PDATA_W-1:0] csr_prdata,
   output logic               csr_pready
);

   bbp_cfg_type cfg;
   logic        busy;

   logic        prep_in_ready;
   logic        prep_valid;
   logic        prep_ready;
   bbp_pre_type prep_item;

   logic         div_valid [0:DATA_W];
   logic         div_ready [0:DATA_W];
   bbp_lane_type div_lane  [0:DATA_W];

   logic              out_valid_ff, out_valid_in;
   logic [DATA_W-1:0] result_ff, result_in;
   logic              oor_ff, oor_in;
   logic              out_take;

   bbp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .busy        (busy)
   );

   // Requests are held off while the derived configuration is being rebuilt.
   assign req_port.ready = prep_in_ready & ~busy;

   bbp_prep u_prep (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_port.valid & ~busy),
      .in_ready    (prep_in_ready),
      .op          (req_port.op),
      .value       (req_port.value),
      .want_column (req_port.want_column),
      .cfg         (cfg),
      .out_valid   (prep_valid),
      .out_ready   (prep_ready),
      .out_item    (prep_item)
   );

   bbp_mul_stage u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_ready  (prep_ready),
      .in_item   (prep_item),
      .out_valid (div_valid[0]),
      .out_ready (div_ready[0]),
      .out_lane  (div_lane[0])
   );

   // Division pipeline, most significant quotient bit first.
   for (genvar i = 0; i < DATA_W; i++) begin : g_div
      bbp_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[i]),
         .in_ready  (div_ready[i]),
         .in_lane   (div_lane[i]),
         .out_valid (div_valid[i+1]),
         .out_ready (div_ready[i+1]),
         .out_lane  (div_lane[i+1])
      );
   end

   // Output register: picks the quotient path or the product path and holds
   // the response until its transfer completes.
   assign div_ready[DATA_W] = ~out_valid_ff | rsp_port.ready;
   assign out_take          = div_ready[DATA_W] & div_valid[DATA_W];
   assign out_valid_in      = div_ready[DATA_W] ? div_valid[DATA_W] : out_valid_ff;

   always_comb begin
      if (div_lane[DATA_W].div_en) begin
         result_in = div_lane[DATA_W].div_add + div_lane[DATA_W].dq;
      end else begin
         result_in = div_lane[DATA_W].prod + div_lane[DATA_W].addend;
      end
      oor_in = div_lane[DATA_W].oor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         result_ff <= result_in;
         oor_ff    <= oor_in;
      end
   end

   assign rsp_port.valid        = out_valid_ff;
   assign rsp_port.result       = result_ff;
   assign rsp_port.out_of_range = oor_ff;

endmodule

// ----- tb/tb_balanced_block_partition.sv -----
// Self-checking testbench for the balanced block partition block.
`timescale 1ns / 1ps

module tb_balanced_block_partition import bbp_pkg::*; ();

   // The op field is two bits wide, but only three codes are defined.
   // The fourth code must answer zero without raising the range flag.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Margin to wait once every outstanding answer is back, so the pipeline drains.
   localparam int DRAIN_CYCLES  = 40;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int RANDOM_ITEMS  = 1600;
   localparam int REPORT_LINES  = 40;

   typedef struct packed {
      logic [DATA_W-1:0] result;
      logic              oor;
   } partition_answer_type;

   logic clock;
   logic reset;

   bbp_req_if req_bus ();
   bbp_rsp_if rsp_bus ();

   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [ADDR_W-1:0]  csr_paddr;
   logic [PDATA_W-1:0] csr_pwdata;
   logic [PDATA_W-1:0] csr_prdata;
   logic               csr_pready;

   // This is the testbench copy of the partition registers.
   // It changes only while the block is idle.
   logic [DATA_W-1:0] cfg_side;
   logic [DATA_W-1:0] cfg_count;
   logic              cfg_by_col;

   partition_answer_type pending_answers[$];

   int mismatch_count;
   int requests_sent;
   int answers_checked;
   int settings_used;
   int sender_burst;
   int cycle_count;

   balanced_block_partition u_top (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_bus),
      .rsp_port    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Compute the answer the block owes for one request under the current settings.
   // Blocks 0 to r-1 hold q+1 elements and the remaining blocks hold q elements.
   // A block count of zero behaves as one block.
   function automatic partition_answer_type partition_lookup(logic [1:0] op,
                                                             logic [DATA_W-1:0] v,
                                                             logic want_col);
      int unsigned n;
      int unsigned q;
      int unsigned r;
      int unsigned big;
      int unsigned lead;
      int unsigned res;
      logic        oor;
      n    = (cfg_count == 0) ? 1 : cfg_count;
      q    = cfg_side / n;
      r    = cfg_side % n;
      big  = q + ((r > 0) ? 1 : 0);
      res  = 0;
      oor  = 1'b0;
      case (op)
         OP_SIZE: begin
            if (v >= n) oor = 1'b1;
            else res = q + ((r > v) ? 1 : 0);
         end
         OP_FIRST: begin
            // The range check takes priority over the forced zero offset.
            if (v >= n) oor = 1'b1;
            else if (cfg_by_col != want_col) res = 0;
            else if (v > r) res = (v - r) * q + r * big;
            else res = v * big;
         end
         OP_OWNER: begin
            if (v >= cfg_side) begin
               oor = 1'b1;
            end else begin
               lead = big * r;
               if (v < lead) res = (big != 0) ? v / big : 0;
               else res = r + ((q != 0) ? (v - lead) / q : 0);
            end
         end
         default: ;
      endcase
      return '{result: DATA_W'(res), oor: oor};
   endfunction

   task automatic flag_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LINES) $display("tb: mismatch: %s", what);
   endtask

   // Compare each response transfer with the oldest expected answer.
   always @(posedge clock) begin
      partition_answer_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_answers.size() == 0) begin
            flag_mismatch($sformatf("response %0h/%0b arrived with no request outstanding",
                                    rsp_bus.result, rsp_bus.out_of_range));
         end else begin
            want = pending_answers.pop_front();
            if (rsp_bus.result !== want.result)
               flag_mismatch($sformatf("response %0d: result %0d, expected %0d",
                                       answers_checked, rsp_bus.result, want.result));
            if (rsp_bus.out_of_range !== want.oor)
               flag_mismatch($sformatf("response %0d: out_of_range %0b, expected %0b",
                                       answers_checked, rsp_bus.out_of_range, want.oor));
            answers_checked++;
         end
      end
   end

   // The response side mostly runs freely, with short stalls.
   // Now and then it stalls for a long time.
   // Some long ready stretches leave the pipeline running without any stall.
   initial begin
      int hold;
      rsp_bus.ready = 1'b0;
      hold = 0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold > 0) begin
            hold--;
         end else if (!rsp_bus.ready) begin
            rsp_bus.ready <= 1'b1;
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(0, 20);
         end else begin
            rsp_bus.ready <= 1'b0;
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                : $urandom_range(0, 2);
         end
      end
   end

   // Send one request. The expected answer is queued at the transfer.
   // The valid signal stays high after the transfer so that back-to-back requests
   // remain possible.
   task automatic send_item(logic [1:0] op, logic [DATA_W-1:0] v, logic want_col);
      int gap;
      int pick;
      pick = $urandom_range(0, 99);
      if (sender_burst > 0) begin
         sender_burst--;
         gap = 0;
      end else if (pick < 3) begin
         sender_burst = $urandom_range(50, 150);
         gap = 0;
      end else if (pick < 60) begin
         gap = 0;
      end else if (pick < 92) begin
         gap = $urandom_range(1, 3);
      end else begin
         gap = $urandom_range(8, 40);
      end
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.op          <= op;
      req_bus.value       <= v;
      req_bus.want_column <= want_col;
      do @(posedge clock); while (!req_bus.ready);
      pending_answers.push_back(partition_lookup(op, v, want_col));
      requests_sent++;
   endtask

   // Stop offering requests and wait until every outstanding answer is back.
   // Then wait long enough for the pipeline to drain completely.
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write one register with an APB transfer. Then read it back.
   // The read access starts straight from the write access phase.
   task automatic write_reg(bbp_reg_type idx, logic [PDATA_W-1:0] data);
      logic [PDATA_W-1:0] stored;
      case (idx)
         REG_SIDE:   stored = data & 32'hFFFF;
         REG_COUNT:  stored = data & 32'hFFFF;
         default:    stored = data & 32'h1;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_W'({idx, 2'b00});
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_SIDE:   cfg_side   = stored[DATA_W-1:0];
         REG_COUNT:  cfg_count  = stored[DATA_W-1:0];
         default:    cfg_by_col = stored[0];
      endcase
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== stored)
         flag_mismatch($sformatf("register %s read back %0h, expected %0h",
                                 idx.name(), csr_prdata, stored));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Change the partition settings only while the block holds no requests.
   task automatic set_partition(logic [DATA_W-1:0] side, logic [DATA_W-1:0] count, logic by_col);
      wait_drained();
      write_reg(REG_SIDE, PDATA_W'(side));
      write_reg(REG_COUNT, PDATA_W'(count));
      write_reg(REG_LAYOUT, PDATA_W'(by_col));
      settings_used++;
   endtask

   // Use the reset settings: one element and one block, column layout.
   task automatic test_reset_settings();
      send_item(OP_SIZE, 16'd0, 1'b1);
      send_item(OP_FIRST, 16'd0, 1'b1);
      send_item(OP_OWNER, 16'd0, 1'b0);
      send_item(OP_OWNER, 16'd1, 1'b0);
      send_item(OP_UNUSED, 16'hFFFF, 1'b1);
   endtask

   // Use the largest side and block count, with indices at the top of their range.
   task automatic test_field_extremes();
      set_partition(16'hFFFF, 16'hFFFF, 1'b1);
      send_item(OP_SIZE, 16'hFFFF, 1'b0);
      send_item(OP_SIZE, 16'hFFFE, 1'b1);
      send_item(OP_FIRST, 16'hFFFE, 1'b1);
      send_item(OP_FIRST, 16'hFFFF, 1'b0);
      send_item(OP_OWNER, 16'hFFFE, 1'b0);
      send_item(OP_OWNER, 16'hFFFF, 1'b1);
      set_partition(16'hFFFF, 16'd1, 1'b0);
      send_item(OP_SIZE, 16'd0, 1'b0);
      send_item(OP_OWNER, 16'hFFFE, 1'b1);
   endtask

   // Check the first index in both layouts. The offset is forced to zero when the layout and the
   // request disagree. Ten elements in three blocks split as 4, 3, 3.
   task automatic test_layout_forcing();
      set_partition(16'd10, 16'd3, 1'b0);
      send_item(OP_FIRST, 16'd1, 1'b0);
      send_item(OP_FIRST, 16'd1, 1'b1);
      set_partition(16'd10, 16'd3, 1'b1);
      send_item(OP_FIRST, 16'd2, 1'b1);
      send_item(OP_FIRST, 16'd2, 1'b0);
   endtask

   // Check a zero side and a zero block count. Also check more blocks than elements,
   // which leaves some blocks empty.
   task automatic test_degenerate_sizes();
      set_partition(16'd0, 16'd0, 1'b1);
      send_item(OP_SIZE, 16'd0, 1'b1);
      send_item(OP_SIZE, 16'd1, 1'b1);
      send_item(OP_OWNER, 16'd0, 1'b1);
      set_partition(16'd3, 16'd7, 1'b1);
      send_item(OP_SIZE, 16'd5, 1'b0);
      send_item(OP_OWNER, 16'd2, 1'b0);
      send_item(OP_FIRST, 16'd6, 1'b1);
   endtask

   // Run random phases. Each phase uses new settings that mix extreme, small and arbitrary sizes.
   // Most requests are in range so that the arithmetic paths do real work.
   // The rest are out of range, unused-op requests, or fully random values.
   task automatic test_random_traffic();
      int unsigned side;
      int unsigned count;
      int unsigned n;
      int          phase_items;
      int          pick;
      int          phase;
      logic [1:0]  op;
      logic [DATA_W-1:0] v;
      phase = 0;
      while (requests_sent < RANDOM_ITEMS + 30) begin
         case ($urandom_range(0, 5))
            0:       side = 16'hFFFF;
            1:       side = $urandom_range(0, 1);
            2, 3:    side = $urandom_range(1, 40);
            default: side = $urandom_range(1, 16'hFFFF);
         endcase
         case ($urandom_range(0, 6))
            0:       count = 0;
            1:       count = 1;
            2:       count = 16'hFFFF;
            3:       count = $urandom_range(1, side + 3);
            4, 5:    count = $urandom_range(1, 16);
            default: count = $urandom_range(1, 16'hFFFF);
         endcase
         set_partition(DATA_W'(side), DATA_W'(count), 1'($urandom));
         n = (count == 0) ? 1 : count;
         phase_items = $urandom_range(15, 45);
         for (int i = 0; i < phase_items; i++) begin
            // The sender waits for an empty pipeline in the middle of the first phase,
            // and now and then later.
            if (i == phase_items / 2 && (phase == 0 || $urandom_range(0, 3) == 0))
               wait_drained();
            op   = 2'($urandom_range(0, 2));
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
               op = OP_UNUSED;
               v  = DATA_W'($urandom);
            end else if (pick < 12) begin
               v = DATA_W'($urandom);
            end else if (pick < 22) begin
               v = (op == OP_OWNER) ? DATA_W'($urandom_range(side, 16'hFFFF))
                                    : DATA_W'($urandom_range(n, 16'hFFFF));
            end else if (op == OP_OWNER) begin
               v = (side == 0) ? DATA_W'($urandom) : DATA_W'($urandom_range(0, side - 1));
            end else begin
               v = DATA_W'($urandom_range(0, n - 1));
            end
            send_item(op, v, 1'($urandom));
         end
         phase++;
      end
   endtask

   // Run watchdog. Reaching the limit means that a handshake never completed.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.op          = OP_SIZE;
      req_bus.value       = '0;
      req_bus.want_column = 1'b0;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      cfg_side            = 16'd1;
      cfg_count           = 16'd1;
      cfg_by_col          = 1'b1;
      mismatch_count      = 0;
      requests_sent       = 0;
      answers_checked     = 0;
      settings_used       = 1;
      sender_burst        = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_settings();
      test_field_extremes();
      test_layout_forcing();
      test_degenerate_sizes();
      test_random_traffic();

      wait_drained();
      if (pending_answers.size() != 0)
         flag_mismatch($sformatf("%0d answers never arrived", pending_answers.size()));
      $display("tb: %0d requests checked under %0d partition settings in %0d cycles",
               answers_checked, settings_used, cycle_count);
      $display("tb: %0d mismatches", mismatch_count);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/bbp_pkg.sv
hdl/bbp_req_if.sv
hdl/bbp_rsp_if.sv
hdl/bbp_csr.sv
hdl/bbp_prep.sv
hdl/bbp_mul_stage.sv
hdl/bbp_div_stage.sv
hdl/balanced_block_partition.sv
tb/tb_balanced_block_partition.sv
